// ===== hdl/bds_pkg.sv =====
// Shared types and constants for the box downsampler.
package bds_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 11;
    localparam int FACTOR_W    = 4;
    localparam int DIM_W       = 11;
    localparam int CHAN_W      = 8;
    localparam int NUM_CHAN    = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_FACTOR     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_OUT_WIDTH  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_OUT_HEIGHT = 2'd2;

    localparam logic [FACTOR_W-1:0] FACTOR_RESET     = 4'd1;
    localparam logic [DIM_W-1:0]    OUT_WIDTH_RESET  = 11'd640;
    localparam logic [DIM_W-1:0]    OUT_HEIGHT_RESET = 11'd480;

    typedef struct packed {
        logic [CHAN_W-1:0] red_in;
        logic [CHAN_W-1:0] green_in;
        logic [CHAN_W-1:0] blue_in;
        logic              frame_start;
    } bds_in_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red_out;
        logic [CHAN_W-1:0] green_out;
        logic [CHAN_W-1:0] blue_out;
        logic              last_of_frame;
    } bds_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIVIDE,
        ST_PUSH
    } bds_state_t;

    typedef struct packed {
        logic capture;
        logic update;
        logic div_step;
        logic out_load;
    } bds_cmd_t;

    typedef struct packed {
        logic block_done;
        logic div_last;
        logic out_free;
    } bds_sts_t;

endpackage

// ===== hdl/bds_stream_if.sv =====
// Valid/ready stream channel carrying one word per handshake.
interface bds_stream_if #(
    parameter type word_t = logic
);
    logic  valid;
    logic  ready;
    word_t data;

    modport source (output valid, input ready, output data);
    modport sink (input valid, output ready, input data);
endinterface

// ===== hdl/bds_ctrl.sv =====
// Controller state machine sequencing capture, update, divide and push.
module bds_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  bds_pkg::bds_sts_t  sts,
    output bds_pkg::bds_cmd_t  cmd
);

    bds_pkg::bds_state_t state_reg;
    bds_pkg::bds_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bds_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            bds_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = bds_pkg::ST_UPDATE;
                end
            end
            bds_pkg::ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = sts.block_done ? bds_pkg::ST_DIVIDE : bds_pkg::ST_IDLE;
            end
            bds_pkg::ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = bds_pkg::ST_PUSH;
                end
            end
            bds_pkg::ST_PUSH:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = bds_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bds_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/bds_divider.sv =====
// Restoring divider, one quotient bit per cycle while step is high, three channels in parallel.
module bds_divider #(
    parameter int SUM_W  = 14,
    parameter int AREA_W = 7
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          start,
    input  logic                                          step,
    input  logic [bds_pkg::NUM_CHAN-1:0][SUM_W-1:0]       dividend,
    input  logic [AREA_W-1:0]                             divisor,
    output logic [bds_pkg::NUM_CHAN-1:0][SUM_W-1:0]       quotient,
    output logic                                          last
);

    localparam int CNT_W = $clog2(SUM_W);

    logic [CNT_W-1:0]                                 count_reg;
    logic [AREA_W-1:0]                                divisor_reg;
    logic [bds_pkg::NUM_CHAN-1:0][SUM_W-1:0]          quo_reg;
    logic [bds_pkg::NUM_CHAN-1:0][SUM_W-1:0]          quo_next;
    logic [bds_pkg::NUM_CHAN-1:0][AREA_W-1:0]         rem_reg;
    logic [bds_pkg::NUM_CHAN-1:0][AREA_W-1:0]         rem_next;

    always_comb
    begin
        logic [AREA_W:0] partial;
        for (int c = 0; c < bds_pkg::NUM_CHAN; c++)
        begin
            partial = {rem_reg[c], quo_reg[c][SUM_W-1]};
            if (partial >= {1'b0, divisor_reg})
            begin
                rem_next[c] = AREA_W'(partial - {1'b0, divisor_reg});
                quo_next[c] = {quo_reg[c][SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[c] = partial[AREA_W-1:0];
                quo_next[c] = {quo_reg[c][SUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (start)
        begin
            count_reg <= '0;
        end
        else if (step)
        begin
            count_reg <= count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            divisor_reg <= divisor;
            quo_reg     <= dividend;
            rem_reg     <= '0;
        end
        else if (step)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient = quo_reg;
    assign last     = (count_reg == CNT_W'(SUM_W - 1));

endmodule

// ===== hdl/bds_datapath.sv =====
// Datapath: configuration, block counters, column sum store, divider and output word.
module bds_datapath #(
    parameter int MAX_OUT_WIDTH  = 1024,
    parameter int MAX_FACTOR     = 8,
    parameter int MAX_OUT_HEIGHT = 1024
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [bds_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [bds_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  bds_pkg::bds_in_t                     in_data,
    input  bds_pkg::bds_cmd_t                    cmd,
    output bds_pkg::bds_sts_t                    sts,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output bds_pkg::bds_out_t                    out_data
);

    localparam int CHAN_MAX = (1 << bds_pkg::CHAN_W) - 1;
    localparam int SUM_W    = $clog2(MAX_FACTOR * MAX_FACTOR * CHAN_MAX + 1);
    localparam int AREA_W   = $clog2(MAX_FACTOR * MAX_FACTOR + 1);
    localparam int FW       = $clog2(MAX_FACTOR + 1);
    localparam int SW       = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1;
    localparam int CW       = $clog2(MAX_OUT_WIDTH);
    localparam int RW       = $clog2(MAX_OUT_HEIGHT);
    localparam int WW       = $clog2(MAX_OUT_WIDTH + 1);
    localparam int HW       = $clog2(MAX_OUT_HEIGHT + 1);
    localparam int NC       = bds_pkg::NUM_CHAN;
    localparam int CH_W     = bds_pkg::CHAN_W;

    logic [bds_pkg::FACTOR_W-1:0] factor_reg;
    logic [bds_pkg::DIM_W-1:0]    out_width_reg;
    logic [bds_pkg::DIM_W-1:0]    out_height_reg;

    logic [FW-1:0]     f_val;
    logic [WW-1:0]     w_val;
    logic [HW-1:0]     h_val;
    logic [SW-1:0]     f_m1;
    logic [CW-1:0]     w_m1;
    logic [RW-1:0]     h_m1;
    logic [AREA_W-1:0] area;

    logic [SW-1:0] sub_col_reg;
    logic [SW-1:0] sub_col_next;
    logic [CW-1:0] out_col_reg;
    logic [CW-1:0] out_col_next;
    logic [SW-1:0] sub_row_reg;
    logic [SW-1:0] sub_row_next;
    logic [RW-1:0] out_row_reg;
    logic [RW-1:0] out_row_next;

    logic [NC-1:0][CH_W-1:0]  pix_reg;
    logic [CW-1:0]            addr_reg;
    logic [CW-1:0]            rd_addr;
    logic [NC-1:0][SUM_W-1:0] sums_mem [MAX_OUT_WIDTH];
    logic [NC-1:0][SUM_W-1:0] rd_data_reg;
    logic [NC-1:0][SUM_W-1:0] sum_next;
    logic [NC-1:0][SUM_W-1:0] quotient;
    logic [NC-1:0][CH_W-1:0]  avg;

    logic first;
    logic col_end;
    logic row_end;
    logic ocol_end;
    logic orow_end;
    logic block_done;
    logic div_last;
    logic last_reg;
    logic out_valid_reg;
    bds_pkg::bds_out_t out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            factor_reg     <= bds_pkg::FACTOR_RESET;
            out_width_reg  <= bds_pkg::OUT_WIDTH_RESET;
            out_height_reg <= bds_pkg::OUT_HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                bds_pkg::REG_FACTOR:     factor_reg     <= cfg_data[bds_pkg::FACTOR_W-1:0];
                bds_pkg::REG_OUT_WIDTH:  out_width_reg  <= cfg_data[bds_pkg::DIM_W-1:0];
                bds_pkg::REG_OUT_HEIGHT: out_height_reg <= cfg_data[bds_pkg::DIM_W-1:0];
                default:                 ;
            endcase
        end
    end

    // clamp registers to their legal ranges
    always_comb
    begin
        priority if (factor_reg == '0)
            f_val = FW'(1);
        else if (32'(factor_reg) > MAX_FACTOR)
            f_val = FW'(MAX_FACTOR);
        else
            f_val = FW'(factor_reg);

        priority if (out_width_reg == '0)
            w_val = WW'(1);
        else if (32'(out_width_reg) > MAX_OUT_WIDTH)
            w_val = WW'(MAX_OUT_WIDTH);
        else
            w_val = WW'(out_width_reg);

        priority if (out_height_reg == '0)
            h_val = HW'(1);
        else if (32'(out_height_reg) > MAX_OUT_HEIGHT)
            h_val = HW'(MAX_OUT_HEIGHT);
        else
            h_val = HW'(out_height_reg);
    end

    assign f_m1 = SW'(f_val - FW'(1));
    assign w_m1 = CW'(w_val - WW'(1));
    assign h_m1 = RW'(h_val - HW'(1));
    assign area = AREA_W'(f_val) * AREA_W'(f_val);

    assign first      = (sub_row_reg == '0) && (sub_col_reg == '0);
    assign col_end    = (sub_col_reg >= f_m1);
    assign row_end    = (sub_row_reg >= f_m1);
    assign ocol_end   = (out_col_reg >= w_m1);
    assign orow_end   = (out_row_reg >= h_m1);
    assign block_done = col_end && row_end;

    always_comb
    begin
        sub_col_next = sub_col_reg;
        out_col_next = out_col_reg;
        sub_row_next = sub_row_reg;
        out_row_next = out_row_reg;
        priority if (!col_end)
        begin
            sub_col_next = sub_col_reg + SW'(1);
        end
        else if (!ocol_end)
        begin
            sub_col_next = '0;
            out_col_next = out_col_reg + CW'(1);
        end
        else if (!row_end)
        begin
            sub_col_next = '0;
            out_col_next = '0;
            sub_row_next = sub_row_reg + SW'(1);
        end
        else
        begin
            sub_col_next = '0;
            out_col_next = '0;
            sub_row_next = '0;
            out_row_next = orow_end ? '0 : out_row_reg + RW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_col_reg <= '0;
            out_col_reg <= '0;
            sub_row_reg <= '0;
            out_row_reg <= '0;
        end
        else if (cmd.capture && in_data.frame_start)
        begin
            sub_col_reg <= '0;
            out_col_reg <= '0;
            sub_row_reg <= '0;
            out_row_reg <= '0;
        end
        else if (cmd.update)
        begin
            sub_col_reg <= sub_col_next;
            out_col_reg <= out_col_next;
            sub_row_reg <= sub_row_next;
            out_row_reg <= out_row_next;
        end
    end

    assign rd_addr = in_data.frame_start ? '0 : out_col_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            pix_reg[0] <= in_data.red_in;
            pix_reg[1] <= in_data.green_in;
            pix_reg[2] <= in_data.blue_in;
            addr_reg   <= rd_addr;
        end
        if (cmd.update)
        begin
            last_reg <= ocol_end && orow_end;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            rd_data_reg <= sums_mem[rd_addr];
        end
        if (cmd.update)
        begin
            sums_mem[addr_reg] <= sum_next;
        end
    end

    // overwrite on the first word of a block, accumulate otherwise
    always_comb
    begin
        for (int c = 0; c < NC; c++)
        begin
            if (first)
                sum_next[c] = SUM_W'(pix_reg[c]);
            else
                sum_next[c] = rd_data_reg[c] + SUM_W'(pix_reg[c]);
        end
    end

    bds_divider #(
        .SUM_W  (SUM_W),
        .AREA_W (AREA_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.update && block_done),
        .step     (cmd.div_step),
        .dividend (sum_next),
        .divisor  (area),
        .quotient (quotient),
        .last     (div_last)
    );

    always_comb
    begin
        for (int c = 0; c < NC; c++)
        begin
            if (quotient[c] > SUM_W'(CHAN_MAX))
                avg[c] = '1;
            else
                avg[c] = CH_W'(quotient[c]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg.red_out       <= avg[0];
            out_data_reg.green_out     <= avg[1];
            out_data_reg.blue_out      <= avg[2];
            out_data_reg.last_of_frame <= last_reg;
        end
    end

    assign sts.block_done = block_done;
    assign sts.div_last   = div_last;
    assign sts.out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== hdl/box_downsample_rgb.sv =====
// Top level of the box downsampler: controller and datapath.
//
//  channel   dir   word                                     handshake
//  samples   sink  red_in, green_in, blue_in, frame_start   valid/ready
//  pixels    src   red_out, green_out, blue_out, last_of_frame  valid/ready
//  cfg       sink  cfg_index, cfg_data                      cfg_write, no stall
//
// A word that completes no block passes through capture with column store read, then update.
// A word that completes a block passes through capture, update, the one-bit-per-cycle divider
// and push; push waits while the output word is still held.
// Reset clears counters, state and output valid; the column store needs no clearing.
// A stalled output holds its word while the next sample word is already taken in.
module box_downsample_rgb #(
    parameter int MAX_OUT_WIDTH  = 1024,
    parameter int MAX_FACTOR     = 8,
    parameter int MAX_OUT_HEIGHT = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [bds_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [bds_pkg::CFG_DATA_W-1:0]    cfg_data,
    bds_stream_if.sink                        samples,
    bds_stream_if.source                      pixels
);

    bds_pkg::bds_cmd_t cmd;
    bds_pkg::bds_sts_t sts;
    logic              in_ready;
    logic              out_valid;
    bds_pkg::bds_out_t out_data;

    bds_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (samples.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bds_datapath #(
        .MAX_OUT_WIDTH  (MAX_OUT_WIDTH),
        .MAX_FACTOR     (MAX_FACTOR),
        .MAX_OUT_HEIGHT (MAX_OUT_HEIGHT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (samples.data),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_ready (pixels.ready),
        .out_data  (out_data)
    );

    assign samples.ready = in_ready;
    assign pixels.valid  = out_valid;
    assign pixels.data   = out_data;

endmodule
